[rtl/mfsp_pkg.sv]
// Package with the types, codes and constants shared by the MIDI file parser modules.
package mfsp_pkg;

    typedef enum logic [17:0] {
        PH_HDR_TAG   = 18'h00001,
        PH_HDR_LEN   = 18'h00002,
        PH_HDR_FMT   = 18'h00004,
        PH_HDR_NTRK  = 18'h00008,
        PH_HDR_DIV   = 18'h00010,
        PH_TRK_TAG   = 18'h00020,
        PH_TRK_LEN   = 18'h00040,
        PH_DELTA     = 18'h00080,
        PH_STATUS    = 18'h00100,
        PH_DATA1     = 18'h00200,
        PH_DATA2     = 18'h00400,
        PH_META_TYPE = 18'h00800,
        PH_META_LEN  = 18'h01000,
        PH_META_BODY = 18'h02000,
        PH_SYX_LEN   = 18'h04000,
        PH_SYX_BODY  = 18'h08000,
        PH_DONE      = 18'h10000,
        PH_HALT      = 18'h20000
    } t_phase;

    localparam logic [2:0] KIND_STATUS  = 3'd0;
    localparam logic [2:0] KIND_HEADER  = 3'd1;
    localparam logic [2:0] KIND_CHANNEL = 3'd2;
    localparam logic [2:0] KIND_TEMPO   = 3'd3;
    localparam logic [2:0] KIND_BEATS   = 3'd4;
    localparam logic [2:0] KIND_TRACK   = 3'd5;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_HDR_TAG  = 3'd1;
    localparam logic [2:0] ERR_HDR_LEN  = 3'd2;
    localparam logic [2:0] ERR_FORMAT   = 3'd3;
    localparam logic [2:0] ERR_TRK_TAG  = 3'd4;
    localparam logic [2:0] ERR_TRUNC    = 3'd5;
    localparam logic [2:0] ERR_OVERRUN  = 3'd6;

    localparam logic [7:0] META_TEMPO   = 8'h51;
    localparam logic [7:0] META_TIMESIG = 8'h58;
    localparam logic [7:0] STATUS_META  = 8'hFF;
    localparam logic [7:0] STATUS_SYS   = 8'hF0;
    localparam logic [3:0] HI_PROGRAM   = 4'hC;
    localparam logic [3:0] HI_PRESSURE  = 4'hD;
    localparam logic [3:0] HI_NOTE_ON   = 4'h9;
    localparam logic [3:0] HI_NOTE_OFF  = 4'h8;

    localparam logic [31:0] TAG_HEADER = 32'h4D546864;
    localparam logic [31:0] TAG_TRACK  = 32'h4D54726B;

    typedef struct packed {
        t_phase      phase;
        logic [1:0]  fbc;
        logic [31:0] word;
        logic [31:0] trk_left;
        logic [15:0] tracks_left;
        logic [15:0] cur_track;
        logic [7:0]  run_status;
        logic [31:0] delta_acc;
        logic [7:0]  evt_status;
        logic [7:0]  first_data;
        logic [7:0]  meta_type;
        logic [31:0] pay_left;
        logic [1:0]  fmt;
        logic        fatal;
    } t_state;

    typedef struct packed {
        logic        emit;
        logic [2:0]  kind;
        logic [15:0] track_index;
        logic [31:0] delta_ticks;
        logic [7:0]  status_byte;
        logic [7:0]  data_one;
        logic [7:0]  data_two;
        logic [23:0] value;
        logic [1:0]  file_format;
        logic [15:0] track_total;
        logic [2:0]  error;
        logic        file_end;
    } t_result;

    localparam t_state STATE_RESET = '{phase: PH_HDR_TAG, default: '0};

endpackage

[rtl/midi_file_stream_parser.sv]
// Top level of the streaming Standard MIDI File parser.
// The parser takes one file byte per transfer and can take a byte in every cycle: each byte
// updates the parse state when it is taken, and the result it causes (at most one) is held
// in an output register, so a new byte is taken whenever that register is empty or is being
// drained in the same cycle. A taken byte's result is in that register in the next cycle.
// It checks the header chunk, walks the counted track chunks, applies running status, and
// reports channel events, tempo, beats per bar, header data and track ends; errors and the
// final byte of the file are flagged on the result fields. After the final byte the parser
// starts over with a new file.
module midi_file_stream_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_byte_value,
    input  logic        i_last_of_file,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [15:0] o_track_index,
    output logic [31:0] o_delta_ticks,
    output logic [7:0]  o_status_byte,
    output logic [7:0]  o_data_one,
    output logic [7:0]  o_data_two,
    output logic [23:0] o_value,
    output logic [1:0]  o_file_format,
    output logic [15:0] o_track_total,
    output logic [2:0]  o_error,
    output logic        o_file_end
);
    import mfsp_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_result n_res;
    t_result r_res;
    logic    r_valid;
    logic    accept;

    mfsp_core u_core (
        .i_state (r_state),
        .i_byte  (i_byte_value),
        .i_last  (i_last_of_file),
        .o_state (n_state),
        .o_res   (n_res)
    );

    // The output register frees up in the same cycle its result is taken.
    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
            r_valid <= 1'b0;
        end else if (accept) begin
            r_state <= n_state;
            r_valid <= n_res.emit;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign o_valid       = r_valid;
    assign o_kind        = r_res.kind;
    assign o_track_index = r_res.track_index;
    assign o_delta_ticks = r_res.delta_ticks;
    assign o_status_byte = r_res.status_byte;
    assign o_data_one    = r_res.data_one;
    assign o_data_two    = r_res.data_two;
    assign o_value       = r_res.value;
    assign o_file_format = r_res.file_format;
    assign o_track_total = r_res.track_total;
    assign o_error       = r_res.error;
    assign o_file_end    = r_res.file_end;

endmodule

[rtl/mfsp_core.sv]
// Next-state and result logic of the MIDI file parser for one input byte.
module mfsp_core (
    input  mfsp_pkg::t_state  i_state,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output mfsp_pkg::t_state  o_state,
    output mfsp_pkg::t_result o_res
);
    import mfsp_pkg::*;

    t_state      s;
    t_state      n;
    t_result     r;
    logic        do_end;
    logic [31:0] word_sh;
    logic [31:0] vlq;
    logic [7:0]  tag_byte_h;
    logic [7:0]  tag_byte_t;
    logic [3:0]  st_hi;
    logic [1:0]  fbc_inc;

    always_comb begin
        s          = i_state;
        n          = i_state;
        r          = '0;
        do_end     = 1'b0;
        word_sh    = {s.word[23:0], i_byte};
        vlq        = {s.pay_left[24:0], i_byte[6:0]};
        tag_byte_h = TAG_HEADER[8'(31 - 8 * int'(s.fbc)) -: 8];
        tag_byte_t = TAG_TRACK[8'(31 - 8 * int'(s.fbc)) -: 8];
        st_hi      = s.evt_status[7:4];
        fbc_inc    = s.fbc + 2'd1;
        r.track_index = s.cur_track;

        unique case (s.phase)
            PH_HDR_TAG, PH_TRK_TAG: begin
                if (i_byte != ((s.phase == PH_HDR_TAG) ? tag_byte_h : tag_byte_t)) begin
                    r.emit  = 1'b1;
                    r.kind  = KIND_STATUS;
                    r.error = (s.phase == PH_HDR_TAG) ? ERR_HDR_TAG : ERR_TRK_TAG;
                    n.fatal = 1'b1;
                    n.phase = PH_HALT;
                end else if (s.fbc == 2'd3) begin
                    n.fbc   = 2'd0;
                    n.phase = (s.phase == PH_HDR_TAG) ? PH_HDR_LEN : PH_TRK_LEN;
                end else begin
                    n.fbc = fbc_inc;
                end
            end
            PH_HDR_LEN, PH_TRK_LEN: begin
                n.word = word_sh;
                if (s.fbc == 2'd3) begin
                    n.fbc = 2'd0;
                    if (s.phase == PH_HDR_LEN) begin
                        if (word_sh != 32'd6) begin
                            r.emit  = 1'b1;
                            r.kind  = KIND_STATUS;
                            r.error = ERR_HDR_LEN;
                            n.fatal = 1'b1;
                            n.phase = PH_HALT;
                        end else begin
                            n.phase = PH_HDR_FMT;
                        end
                    end else begin
                        n.trk_left   = word_sh;
                        n.run_status = 8'd0;
                        n.delta_acc  = 32'd0;
                        n.phase      = PH_DELTA;
                        do_end       = (word_sh == 32'd0);
                    end
                end else begin
                    n.fbc = fbc_inc;
                end
            end
            PH_HDR_FMT, PH_HDR_NTRK, PH_HDR_DIV: begin
                n.word = word_sh;
                if (s.fbc >= 2'd1) begin
                    n.fbc = 2'd0;
                    if (s.phase == PH_HDR_FMT) begin
                        if (word_sh[15:0] > 16'd2) begin
                            r.emit  = 1'b1;
                            r.kind  = KIND_STATUS;
                            r.error = ERR_FORMAT;
                            n.fatal = 1'b1;
                            n.phase = PH_HALT;
                        end else begin
                            n.fmt   = word_sh[1:0];
                            n.phase = PH_HDR_NTRK;
                        end
                    end else if (s.phase == PH_HDR_NTRK) begin
                        n.tracks_left = word_sh[15:0];
                        n.phase       = PH_HDR_DIV;
                    end else begin
                        r.emit        = 1'b1;
                        r.kind        = KIND_HEADER;
                        r.value       = {8'd0, word_sh[15:0]};
                        r.file_format = s.fmt;
                        r.track_total = s.tracks_left;
                        n.phase       = (s.tracks_left != 16'd0) ? PH_TRK_TAG : PH_DONE;
                    end
                end else begin
                    n.fbc = fbc_inc;
                end
            end
            PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2, PH_META_TYPE, PH_META_LEN,
            PH_META_BODY, PH_SYX_LEN, PH_SYX_BODY: begin
                if (s.trk_left == 32'd0) begin
                    do_end = 1'b1;
                end else begin
                    n.trk_left = s.trk_left - 32'd1;
                    unique case (s.phase)
                        PH_DELTA: begin
                            n.delta_acc = {s.delta_acc[24:0], i_byte[6:0]};
                            if (!i_byte[7]) begin
                                n.phase = PH_STATUS;
                            end
                        end
                        PH_STATUS: begin
                            if (!i_byte[7]) begin
                                if (s.run_status == 8'd0) begin
                                    r.emit        = 1'b1;
                                    r.kind        = KIND_CHANNEL;
                                    r.delta_ticks = s.delta_acc;
                                    n.delta_acc   = {24'd0, i_byte};
                                end else begin
                                    n.evt_status = s.run_status;
                                    n.first_data = i_byte;
                                    if (s.run_status[7:4] == HI_PROGRAM ||
                                        s.run_status[7:4] == HI_PRESSURE) begin
                                        r.emit        = 1'b1;
                                        r.kind        = KIND_CHANNEL;
                                        r.delta_ticks = s.delta_acc;
                                        r.status_byte = s.run_status;
                                        r.data_one    = i_byte;
                                        n.delta_acc   = 32'd0;
                                        n.phase       = PH_DELTA;
                                    end else begin
                                        n.phase = PH_DATA2;
                                    end
                                end
                            end else if (i_byte == STATUS_META) begin
                                n.run_status = 8'd0;
                                n.phase      = PH_META_TYPE;
                            end else if (i_byte >= STATUS_SYS) begin
                                n.run_status = 8'd0;
                                n.pay_left   = 32'd0;
                                n.phase      = PH_SYX_LEN;
                            end else begin
                                n.run_status = i_byte;
                                n.evt_status = i_byte;
                                n.phase      = PH_DATA1;
                            end
                        end
                        PH_DATA1: begin
                            n.first_data = i_byte;
                            if (st_hi == HI_PROGRAM || st_hi == HI_PRESSURE) begin
                                r.emit        = 1'b1;
                                r.kind        = KIND_CHANNEL;
                                r.delta_ticks = s.delta_acc;
                                r.status_byte = s.evt_status;
                                r.data_one    = i_byte;
                                n.delta_acc   = 32'd0;
                                n.phase       = PH_DELTA;
                            end else begin
                                n.phase = PH_DATA2;
                            end
                        end
                        PH_DATA2: begin
                            r.emit        = 1'b1;
                            r.kind        = KIND_CHANNEL;
                            r.delta_ticks = s.delta_acc;
                            // A note-on with zero velocity is a note-off.
                            r.status_byte = (st_hi == HI_NOTE_ON && i_byte == 8'd0) ?
                                            {HI_NOTE_OFF, s.evt_status[3:0]} : s.evt_status;
                            r.data_one    = s.first_data;
                            r.data_two    = i_byte;
                            n.delta_acc   = 32'd0;
                            n.phase       = PH_DELTA;
                        end
                        PH_META_TYPE: begin
                            n.meta_type = i_byte;
                            n.pay_left  = 32'd0;
                            n.phase     = PH_META_LEN;
                        end
                        PH_META_LEN: begin
                            n.pay_left = vlq;
                            if (!i_byte[7]) begin
                                if (vlq > n.trk_left) begin
                                    n.pay_left = n.trk_left;
                                    r.emit     = 1'b1;
                                    r.kind     = KIND_STATUS;
                                    r.error    = ERR_OVERRUN;
                                end
                                if (s.meta_type == META_TEMPO && n.pay_left < 32'd3) begin
                                    n.meta_type = 8'd0;
                                end
                                if (s.meta_type == META_TIMESIG && n.pay_left < 32'd2) begin
                                    n.meta_type = 8'd0;
                                end
                                n.fbc  = 2'd0;
                                n.word = 32'd0;
                                if (n.pay_left != 32'd0) begin
                                    n.phase = PH_META_BODY;
                                end else begin
                                    n.delta_acc = 32'd0;
                                    n.phase     = PH_DELTA;
                                end
                            end
                        end
                        PH_META_BODY: begin
                            n.pay_left = s.pay_left - 32'd1;
                            if (s.meta_type == META_TEMPO && s.fbc < 2'd3) begin
                                n.word = word_sh;
                                n.fbc  = fbc_inc;
                                if (fbc_inc == 2'd3) begin
                                    r.emit  = 1'b1;
                                    r.kind  = KIND_TEMPO;
                                    r.value = word_sh[23:0];
                                end
                            end else if (s.meta_type == META_TIMESIG && s.fbc == 2'd0) begin
                                n.fbc   = 2'd1;
                                r.emit  = 1'b1;
                                r.kind  = KIND_BEATS;
                                r.value = {16'd0, i_byte};
                            end
                            if (n.pay_left == 32'd0) begin
                                n.delta_acc = 32'd0;
                                n.phase     = PH_DELTA;
                            end
                        end
                        PH_SYX_LEN: begin
                            n.pay_left = vlq;
                            if (!i_byte[7]) begin
                                if (vlq != 32'd0) begin
                                    n.phase = PH_SYX_BODY;
                                end else begin
                                    n.delta_acc = 32'd0;
                                    n.phase     = PH_DELTA;
                                end
                            end
                        end
                        default: begin
                            n.pay_left = s.pay_left - 32'd1;
                            if (n.pay_left == 32'd0) begin
                                n.delta_acc = 32'd0;
                                n.phase     = PH_DELTA;
                            end
                        end
                    endcase
                    if (n.trk_left == 32'd0) begin
                        do_end = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        if (do_end) begin
            if (!r.emit || r.kind == KIND_STATUS) begin
                r.emit = 1'b1;
                r.kind = KIND_TRACK;
            end
            n.run_status  = 8'd0;
            n.cur_track   = s.cur_track + 16'd1;
            n.tracks_left = s.tracks_left - 16'd1;
            n.fbc         = 2'd0;
            n.phase       = (n.tracks_left != 16'd0) ? PH_TRK_TAG : PH_DONE;
        end

        if (i_last) begin
            r.emit     = 1'b1;
            r.file_end = 1'b1;
            if (n.phase != PH_DONE && n.phase != PH_HALT && !n.fatal) begin
                r.error = ERR_TRUNC;
            end
            n = STATE_RESET;
        end
    end

    assign o_state = n;
    assign o_res   = r;

endmodule

[sim/tb.sv]
// Self-checking testbench for the streaming MIDI file parser.
module tb;
    import mfsp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_byte;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_byte_value;
    logic        i_last_of_file;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_kind;
    logic [15:0] o_track_index;
    logic [31:0] o_delta_ticks;
    logic [7:0]  o_status_byte;
    logic [7:0]  o_data_one;
    logic [7:0]  o_data_two;
    logic [23:0] o_value;
    logic [1:0]  o_file_format;
    logic [15:0] o_track_total;
    logic [2:0]  o_error;
    logic        o_file_end;

    midi_file_stream_parser dut (.*);

    // Bytes waiting for the driver, and parse results still owed by the block.
    t_byte   byte_fifo[$];
    t_result owed_results[$];
    // Scratch buffers used while a file and one of its tracks are assembled.
    logic [7:0] file_buf[$];
    logic [7:0] track_buf[$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned fail_count;
    int unsigned bytes_taken;
    int unsigned results_seen;
    int unsigned files_built;
    int unsigned quiet_cycles;
    bit          took;

    // Shadow copy of the parser state, kept in step with every accepted byte.
    t_phase      ph;
    logic [1:0]  fbc;
    logic [31:0] word;
    logic [31:0] trk_left;
    logic [15:0] tracks_left;
    logic [15:0] cur_track;
    logic [7:0]  run_status;
    logic [31:0] delta_acc;
    logic [7:0]  evt_status;
    logic [7:0]  first_byte;
    logic [7:0]  meta_kind;
    logic [31:0] pay_left;
    logic [1:0]  fmt_seen;
    logic        fatal;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic clear_parser();
        ph          = PH_HDR_TAG;
        fbc         = '0;
        word        = '0;
        trk_left    = '0;
        tracks_left = '0;
        cur_track   = '0;
        run_status  = '0;
        delta_acc   = '0;
        evt_status  = '0;
        first_byte  = '0;
        meta_kind   = '0;
        pay_left    = '0;
        fmt_seen    = '0;
        fatal       = 1'b0;
    endtask

    task automatic raise_fatal(inout t_result r, input logic [2:0] code);
        r.emit  = 1'b1;
        r.kind  = KIND_STATUS;
        r.error = code;
        fatal   = 1'b1;
        ph      = PH_HALT;
    endtask

    // Shifts a byte into the word; returns 1 once n bytes of the field are in.
    function automatic bit shift_field(input logic [7:0] b, input int n);
        word = {word[23:0], b};
        if (fbc >= n - 1) begin
            fbc = '0;
            return 1'b1;
        end
        fbc = fbc + 2'd1;
        return 1'b0;
    endfunction

    task automatic start_delta();
        delta_acc = '0;
        ph        = PH_DELTA;
    endtask

    task automatic channel_out(inout t_result r, input logic [7:0] st,
                               input logic [7:0] a, input logic [7:0] c);
        r.emit        = 1'b1;
        r.kind        = KIND_CHANNEL;
        r.delta_ticks = delta_acc;
        r.status_byte = st;
        r.data_one    = a;
        r.data_two    = c;
    endtask

    task automatic first_data_in(inout t_result r, input logic [7:0] b);
        first_byte = b;
        if (evt_status[7:4] == HI_PROGRAM || evt_status[7:4] == HI_PRESSURE) begin
            channel_out(r, evt_status, b, 8'h00);
            start_delta();
        end else begin
            ph = PH_DATA2;
        end
    endtask

    // A track end only shows as its own kind when the byte produced nothing
    // better; an error code already on the result rides along with it.
    task automatic close_track(inout t_result r);
        if (!r.emit || r.kind == KIND_STATUS) begin
            r.emit = 1'b1;
            r.kind = KIND_TRACK;
        end
        run_status  = '0;
        cur_track   = cur_track + 16'd1;
        tracks_left = tracks_left - 16'd1;
        fbc         = '0;
        ph          = (tracks_left != 0) ? PH_TRK_TAG : PH_DONE;
    endtask

    task automatic track_byte(inout t_result r, input logic [7:0] b);
        logic [7:0] st;
        case (ph)
            PH_DELTA: begin
                delta_acc = {delta_acc[24:0], b[6:0]};
                if (!b[7]) ph = PH_STATUS;
            end
            PH_STATUS: begin
                if (!b[7]) begin
                    if (run_status == 0) begin
                        // A data byte with no status to run on: report an empty
                        // event and take the byte as the next delta.
                        channel_out(r, 8'h00, 8'h00, 8'h00);
                        delta_acc = {24'h0, b};
                    end else begin
                        evt_status = run_status;
                        first_data_in(r, b);
                    end
                end else if (b == STATUS_META) begin
                    run_status = '0;
                    ph         = PH_META_TYPE;
                end else if (b >= STATUS_SYS) begin
                    run_status = '0;
                    pay_left   = '0;
                    ph         = PH_SYX_LEN;
                end else begin
                    run_status = b;
                    evt_status = b;
                    ph         = PH_DATA1;
                end
            end
            PH_DATA1: first_data_in(r, b);
            PH_DATA2: begin
                st = evt_status;
                if (st[7:4] == HI_NOTE_ON && b == 0) st = {HI_NOTE_OFF, st[3:0]};
                channel_out(r, st, first_byte, b);
                start_delta();
            end
            PH_META_TYPE: begin
                meta_kind = b;
                pay_left  = '0;
                ph        = PH_META_LEN;
            end
            PH_META_LEN: begin
                pay_left = {pay_left[24:0], b[6:0]};
                if (!b[7]) begin
                    if (pay_left > trk_left) begin
                        pay_left = trk_left;
                        r.emit   = 1'b1;
                        r.kind   = KIND_STATUS;
                        r.error  = ERR_OVERRUN;
                    end
                    if (meta_kind == META_TEMPO && pay_left < 3) meta_kind = '0;
                    if (meta_kind == META_TIMESIG && pay_left < 2) meta_kind = '0;
                    fbc  = '0;
                    word = '0;
                    if (pay_left != 0) ph = PH_META_BODY;
                    else start_delta();
                end
            end
            PH_META_BODY: begin
                pay_left = pay_left - 32'd1;
                if (meta_kind == META_TEMPO && fbc < 3) begin
                    word = {word[23:0], b};
                    fbc  = fbc + 2'd1;
                    if (fbc == 3) begin
                        r.emit  = 1'b1;
                        r.kind  = KIND_TEMPO;
                        r.error = ERR_NONE;
                        r.value = word[23:0];
                    end
                end else if (meta_kind == META_TIMESIG && fbc == 0) begin
                    fbc     = 2'd1;
                    r.emit  = 1'b1;
                    r.kind  = KIND_BEATS;
                    r.value = {16'h0, b};
                end
                if (pay_left == 0) start_delta();
            end
            PH_SYX_LEN: begin
                pay_left = {pay_left[24:0], b[6:0]};
                if (!b[7]) begin
                    if (pay_left != 0) ph = PH_SYX_BODY;
                    else start_delta();
                end
            end
            default: begin
                pay_left = pay_left - 32'd1;
                if (pay_left == 0) start_delta();
            end
        endcase
    endtask

    // Works out the result (if any) that one accepted byte must produce.
    task automatic parse_byte(input logic [7:0] b, input logic last, output t_result r);
        logic [15:0] trk;
        trk = cur_track;
        r   = '0;
        case (ph)
            PH_HDR_TAG: begin
                if (b != TAG_HEADER[31 - 8 * fbc -: 8]) raise_fatal(r, ERR_HDR_TAG);
                else if (fbc == 3) begin
                    fbc = '0;
                    ph  = PH_HDR_LEN;
                end else fbc = fbc + 2'd1;
            end
            PH_HDR_LEN: begin
                if (shift_field(b, 4)) begin
                    if (word != 32'd6) raise_fatal(r, ERR_HDR_LEN);
                    else ph = PH_HDR_FMT;
                end
            end
            PH_HDR_FMT: begin
                if (shift_field(b, 2)) begin
                    if (word[15:0] > 2) raise_fatal(r, ERR_FORMAT);
                    else begin
                        fmt_seen = word[1:0];
                        ph       = PH_HDR_NTRK;
                    end
                end
            end
            PH_HDR_NTRK: begin
                if (shift_field(b, 2)) begin
                    tracks_left = word[15:0];
                    ph          = PH_HDR_DIV;
                end
            end
            PH_HDR_DIV: begin
                if (shift_field(b, 2)) begin
                    r.emit        = 1'b1;
                    r.kind        = KIND_HEADER;
                    r.value       = {8'h0, word[15:0]};
                    r.file_format = fmt_seen;
                    r.track_total = tracks_left;
                    ph            = (tracks_left != 0) ? PH_TRK_TAG : PH_DONE;
                end
            end
            PH_TRK_TAG: begin
                if (b != TAG_TRACK[31 - 8 * fbc -: 8]) raise_fatal(r, ERR_TRK_TAG);
                else if (fbc == 3) begin
                    fbc = '0;
                    ph  = PH_TRK_LEN;
                end else fbc = fbc + 2'd1;
            end
            PH_TRK_LEN: begin
                if (shift_field(b, 4)) begin
                    trk_left   = word;
                    run_status = '0;
                    start_delta();
                    if (trk_left == 0) close_track(r);
                end
            end
            PH_DONE, PH_HALT: ;
            default: begin
                if (trk_left == 0) close_track(r);
                else begin
                    trk_left = trk_left - 32'd1;
                    track_byte(r, b);
                    if (trk_left == 0) close_track(r);
                end
            end
        endcase
        if (last) begin
            r.emit     = 1'b1;
            r.file_end = 1'b1;
            if (ph != PH_DONE && ph != PH_HALT && !fatal) r.error = ERR_TRUNC;
            clear_parser();
        end
        r.track_index = trk;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Driver: a byte stays on the port until its transfer, then the next one
    // may follow at once or only after a random run of idle cycles.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || took) begin
                if (byte_fifo.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_byte_value   <= byte_fifo[0].data;
                    i_last_of_file <= byte_fifo[0].last;
                    void'(byte_fifo.pop_front());
                    i_valid        <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: checks each result transfer against the oldest owed result,
    // then predicts the result of a byte transfer in the same cycle.
    always @(posedge i_clk) begin
        t_result want;
        t_result pred;
        if (i_rst_n) begin
            took = i_valid && o_ready;
            if (o_valid && i_ready) begin
                results_seen++;
                if (owed_results.size() == 0) begin
                    $error("result transfer with no result owed (kind %0d)", o_kind);
                    fail_count++;
                end else begin
                    want = owed_results.pop_front();
                    compare_field("kind", want.kind, o_kind);
                    compare_field("track_index", want.track_index, o_track_index);
                    compare_field("delta_ticks", want.delta_ticks, o_delta_ticks);
                    compare_field("status_byte", want.status_byte, o_status_byte);
                    compare_field("data_one", want.data_one, o_data_one);
                    compare_field("data_two", want.data_two, o_data_two);
                    compare_field("value", want.value, o_value);
                    compare_field("file_format", want.file_format, o_file_format);
                    compare_field("track_total", want.track_total, o_track_total);
                    compare_field("error", want.error, o_error);
                    compare_field("file_end", want.file_end, o_file_end);
                end
            end
            if (took) begin
                bytes_taken++;
                parse_byte(i_byte_value, i_last_of_file, pred);
                if (pred.emit) owed_results.insert(owed_results.size(), pred);
            end
            if (took || (o_valid && i_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= 5000) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic put_vlq(input logic [31:0] v, input int n, input bit to_track);
        logic [7:0] b;
        for (int k = n - 1; k >= 0; k--) begin
            b = {(k != 0), 7'(v >> (7 * k))};
            if (to_track) track_buf.insert(track_buf.size(), b);
            else file_buf.insert(file_buf.size(), b);
        end
    endtask

    // Builds one track body of random events; an overrunning meta event or
    // garbage bytes may appear among well-formed ones.
    task automatic build_track();
        logic [7:0] st;
        logic [7:0] rs;
        int         nev;
        int         len;
        rs  = '0;
        nev = $urandom_range(1, 10);
        track_buf.delete();
        for (int e = 0; e < nev; e++) begin
            put_vlq($urandom(), ($urandom_range(3) == 0) ? $urandom_range(2, 5) : 1, 1'b1);
            case ($urandom_range(0, 10))
                0, 1, 2: begin
                    st = 8'($urandom_range(8'h80, 8'hEF));
                    rs = st;
                    track_buf.insert(track_buf.size(), st);
                    track_buf.insert(track_buf.size(), 8'($urandom_range(0, 127)));
                    if (st[7:4] != HI_PROGRAM && st[7:4] != HI_PRESSURE)
                        track_buf.insert(track_buf.size(),
                                         (st[7:4] == HI_NOTE_ON && $urandom_range(1) == 0)
                                         ? 8'h00 : 8'($urandom_range(0, 127)));
                end
                3, 4: begin
                    // Running status, or a stray data byte when none is in force.
                    track_buf.insert(track_buf.size(), 8'($urandom_range(0, 127)));
                    if (rs != 0 && rs[7:4] != HI_PROGRAM && rs[7:4] != HI_PRESSURE)
                        track_buf.insert(track_buf.size(), 8'($urandom_range(0, 127)));
                end
                5, 6: begin
                    len = ($urandom_range(2) == 0) ? $urandom_range(0, 5) :
                          ($urandom_range(1) ? 3 : 4);
                    track_buf.insert(track_buf.size(), STATUS_META);
                    track_buf.insert(track_buf.size(),
                                     $urandom_range(1) ? META_TEMPO : META_TIMESIG);
                    put_vlq(len, 1, 1'b1);
                    for (int k = 0; k < len; k++)
                        track_buf.insert(track_buf.size(), 8'($urandom()));
                    rs = '0;
                end
                7: begin
                    len = $urandom_range(0, 6);
                    track_buf.insert(track_buf.size(), STATUS_META);
                    track_buf.insert(track_buf.size(), 8'($urandom()));
                    put_vlq(len, $urandom_range(1, 2), 1'b1);
                    for (int k = 0; k < len; k++)
                        track_buf.insert(track_buf.size(), 8'($urandom()));
                    rs = '0;
                end
                8: begin
                    len = $urandom_range(0, 6);
                    track_buf.insert(track_buf.size(), $urandom_range(1) ? STATUS_SYS :
                                     8'($urandom_range(8'hF1, 8'hFE)));
                    put_vlq(len, $urandom_range(1, 2), 1'b1);
                    for (int k = 0; k < len; k++)
                        track_buf.insert(track_buf.size(), 8'($urandom()));
                    rs = '0;
                end
                9: track_buf.insert(track_buf.size(), 8'($urandom()));
                default: begin
                    // A meta event that claims more bytes than the track holds.
                    track_buf.insert(track_buf.size(), STATUS_META);
                    track_buf.insert(track_buf.size(), $urandom_range(1) ? META_TEMPO : 8'h01);
                    put_vlq($urandom_range(40, 200), 2, 1'b1);
                    for (int k = $urandom_range(0, 4); k > 0; k--)
                        track_buf.insert(track_buf.size(), 8'($urandom()));
                    break;
                end
            endcase
        end
    endtask

    // Builds one file, mostly well formed, sometimes broken on purpose, and
    // queues it with the final byte flagged.
    task automatic queue_file();
        int          mode;
        int          ntrk;
        logic [15:0] fmt;
        logic [31:0] len;
        mode = $urandom_range(0, 13);
        ntrk = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 3);
        fmt  = (mode == 9) ? 16'($urandom_range(3, 65535)) : 16'($urandom_range(0, 2));
        file_buf.delete();
        for (int k = 0; k < 4; k++)
            file_buf.insert(file_buf.size(), TAG_HEADER[31 - 8 * k -: 8]);
        file_buf.insert(file_buf.size(), 8'h00);
        file_buf.insert(file_buf.size(), 8'h00);
        file_buf.insert(file_buf.size(), 8'h00);
        file_buf.insert(file_buf.size(), 8'h06);
        file_buf.insert(file_buf.size(), fmt[15:8]);
        file_buf.insert(file_buf.size(), fmt[7:0]);
        file_buf.insert(file_buf.size(), 8'(ntrk >> 8));
        file_buf.insert(file_buf.size(), 8'(ntrk));
        file_buf.insert(file_buf.size(), 8'($urandom()));
        file_buf.insert(file_buf.size(), 8'($urandom()));
        for (int t = 0; t < ntrk; t++) begin
            build_track();
            len = track_buf.size();
            if ($urandom_range(9) == 0) len = len + $urandom_range(0, 6) - 3;
            if ($urandom_range(30) == 0) len = 0;
            for (int k = 0; k < 4; k++)
                file_buf.insert(file_buf.size(), TAG_TRACK[31 - 8 * k -: 8]);
            for (int k = 3; k >= 0; k--) file_buf.insert(file_buf.size(), 8'(len >> (8 * k)));
            foreach (track_buf[k]) file_buf.insert(file_buf.size(), track_buf[k]);
        end
        case (mode)
            7:  file_buf[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
            8:  file_buf[$urandom_range(4, 7)] ^= 8'($urandom_range(1, 255));
            10: if (ntrk > 0) file_buf[$urandom_range(14, 17)] ^= 8'($urandom_range(1, 255));
            11: while (file_buf.size() > 1 && $urandom_range(3) != 0)
                    void'(file_buf.pop_back());
            12: for (int k = $urandom_range(1, 5); k > 0; k--)
                    file_buf.insert(file_buf.size(), 8'($urandom()));
            default: ;
        endcase
        foreach (file_buf[k])
            byte_fifo.insert(byte_fifo.size(), '{file_buf[k], (k == file_buf.size() - 1)});
        files_built++;
    endtask

    task automatic drain();
        while (byte_fifo.size() > 0 || i_valid || owed_results.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int unsigned goal;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_ready        = 1'b0;
        i_byte_value   = '0;
        i_last_of_file = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fail_count     = 0;
        bytes_taken    = 0;
        results_seen   = 0;
        files_built    = 0;
        quiet_cycles   = 0;
        took           = 1'b0;
        clear_parser();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: a header tag that breaks on its second byte, then a file
        // of zero tracks that ends right after its header.
        byte_fifo.insert(byte_fifo.size(), '{8'h4D, 1'b0});
        byte_fifo.insert(byte_fifo.size(), '{8'hFF, 1'b1});
        for (int k = 0; k < 4; k++)
            byte_fifo.insert(byte_fifo.size(), '{TAG_HEADER[31 - 8 * k -: 8], 1'b0});
        byte_fifo.insert(byte_fifo.size(), '{8'h00, 1'b0});
        byte_fifo.insert(byte_fifo.size(), '{8'h00, 1'b0});
        byte_fifo.insert(byte_fifo.size(), '{8'h00, 1'b0});
        byte_fifo.insert(byte_fifo.size(), '{8'h06, 1'b0});
        byte_fifo.insert(byte_fifo.size(), '{8'h00, 1'b0});
        byte_fifo.insert(byte_fifo.size(), '{8'h02, 1'b0});
        byte_fifo.insert(byte_fifo.size(), '{8'h00, 1'b0});
        byte_fifo.insert(byte_fifo.size(), '{8'h00, 1'b0});
        byte_fifo.insert(byte_fifo.size(), '{8'hFF, 1'b0});
        byte_fifo.insert(byte_fifo.size(), '{8'hFF, 1'b1});
        drain();

        // Random files under four flow-control regimes.
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = (p == 1 || p == 3) ? ((p == 3) ? 21 : 63) : 0;
            recv_stall_pct = (p == 2 || p == 3) ? ((p == 3) ? 21 : 63) : 0;
            goal = bytes_taken + 335;
            while (bytes_taken + byte_fifo.size() < goal) queue_file();
            drain();
        end

        $display("Run covered %0d files, %0d bytes and %0d results", files_built,
                 bytes_taken, results_seen);
        $display("under four idle and stall regimes, with %0d mismatches.", fail_count);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/mfsp_pkg.sv
rtl/mfsp_core.sv
rtl/midi_file_stream_parser.sv
sim/tb.sv
